// ----- design/mbe_pkg.sv -----
// Package for the minimum bottleneck spanning tree block.
// Holds sizes, request codes, controller state codes and the command/status bundles.
// No dependencies.
package mbe_pkg;

  localparam int MaxVertices = 256;
  localparam int MaxEdges    = 1024;
  localparam int WeightBits  = 16;
  localparam int VtxBits     = 8;
  localparam int EaddrBits   = 10;
  localparam int EcntBits    = 11;
  localparam int NBits       = 9;
  localparam int EdgeBits    = WeightBits + 2 * VtxBits;

  localparam logic [WeightBits-1:0] WeightMax = {WeightBits{1'b1}};

  // request codes on req_type
  localparam logic ReqEdge   = 1'b0;
  localparam logic ReqFinish = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CHK_INIT = 10'b00_0000_0010,
    ST_E_RD     = 10'b00_0000_0100,
    ST_E_EVAL   = 10'b00_0000_1000,
    ST_FA_RD    = 10'b00_0001_0000,
    ST_FA_EVAL  = 10'b00_0010_0000,
    ST_FB_RD    = 10'b00_0100_0000,
    ST_FB_EVAL  = 10'b00_1000_0000,
    ST_CHK_END  = 10'b01_0000_0000,
    ST_EMIT     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic search_init;
    logic chk_init;
    logic e_rd;
    logic next_edge;
    logic start_a;
    logic f_rd;
    logic step;
    logic save_ra;
    logic link;
    logic search_upd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic total_zero;
    logic edges_done;
    logic edge_skip;
    logic is_root;
    logic same_root;
    logic search_fin;
    logic out_free;
  } stat_t;

endpackage

// ----- design/mbe_datapath.sv -----
// Datapath: edge store, union-find forest, threshold search and result register.
// Driven by mbe_ctrl commands; uses mbe_pkg.
module mbe_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbe_pkg::NBits-1:0]        cfg_wdata,
  input  logic [mbe_pkg::VtxBits-1:0]      end_a,
  input  logic [mbe_pkg::VtxBits-1:0]      end_b,
  input  logic [mbe_pkg::WeightBits-1:0]   edge_weight,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [mbe_pkg::WeightBits-1:0]   max_tree_weight,
  output logic                             feasible,
  input  mbe_pkg::cmd_t                    cmd,
  output mbe_pkg::stat_t                   stat
);

  logic [mbe_pkg::EdgeBits-1:0]   edge_mem [mbe_pkg::MaxEdges];
  logic [mbe_pkg::VtxBits-1:0]    parent_mem [mbe_pkg::MaxVertices];
  logic [mbe_pkg::MaxVertices-1:0] pvalid;

  logic [mbe_pkg::NBits-1:0]      vcount;
  logic [mbe_pkg::EcntBits-1:0]   total;
  logic [mbe_pkg::EcntBits-1:0]   eidx;
  logic [mbe_pkg::EdgeBits-1:0]   eq;
  logic [mbe_pkg::VtxBits-1:0]    pq;
  logic                           vq;
  logic [mbe_pkg::VtxBits-1:0]    cur;
  logic [mbe_pkg::VtxBits-1:0]    ra;
  logic [mbe_pkg::NBits-1:0]      unions;
  logic [mbe_pkg::WeightBits-1:0] lo, hi, thr;
  logic                           first, fail;

  logic [mbe_pkg::NBits-1:0]      n_eff;
  logic [mbe_pkg::VtxBits-1:0]    e_a, e_b, pval;
  logic [mbe_pkg::WeightBits-1:0] e_w, lo_next, hi_next;
  logic [mbe_pkg::WeightBits:0]   mid_sum;
  logic                           conn, fail_next;

  assign n_eff = (vcount == '0) ? mbe_pkg::NBits'(1)
               : (vcount > mbe_pkg::NBits'(mbe_pkg::MaxVertices))
                 ? mbe_pkg::NBits'(mbe_pkg::MaxVertices) : vcount;
  assign e_a  = eq[mbe_pkg::VtxBits-1:0];
  assign e_b  = eq[2*mbe_pkg::VtxBits-1:mbe_pkg::VtxBits];
  assign e_w  = eq[mbe_pkg::EdgeBits-1:2*mbe_pkg::VtxBits];
  assign pval = vq ? pq : cur;
  assign conn = (unions == n_eff - mbe_pkg::NBits'(1));

  // threshold search: first pass at the top weight, then bisect
  always_comb begin
    lo_next   = lo;
    hi_next   = hi;
    fail_next = 1'b0;
    if (first) begin
      fail_next = !conn;
    end else if (conn) begin
      hi_next = thr;
    end else begin
      lo_next = thr + mbe_pkg::WeightBits'(1);
    end
    mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
  end

  assign stat.total_zero = (total == '0);
  assign stat.edges_done = (eidx >= total);
  assign stat.edge_skip  = (e_w > thr) || ({1'b0, e_a} >= n_eff) || ({1'b0, e_b} >= n_eff);
  assign stat.is_root    = (pval == cur);
  assign stat.same_root  = (ra == cur);
  assign stat.search_fin = fail_next || (lo_next >= hi_next);
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && total < mbe_pkg::EcntBits'(mbe_pkg::MaxEdges)) begin
      edge_mem[total[mbe_pkg::EaddrBits-1:0]] <= {edge_weight, end_b, end_a};
    end
    if (cmd.e_rd) begin
      eq <= edge_mem[eidx[mbe_pkg::EaddrBits-1:0]];
    end
    if (cmd.link) begin
      parent_mem[ra] <= cur;
    end
    if (cmd.f_rd) begin
      pq <= parent_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.f_rd) vq <= pvalid[cur];
    if (cmd.start_a) cur <= e_a;
    if (cmd.step) cur <= pval;
    if (cmd.save_ra) begin
      ra  <= cur;
      cur <= e_b;
    end
    if (cmd.search_init) begin
      lo  <= '0;
      hi  <= mbe_pkg::WeightMax;
      thr <= mbe_pkg::WeightMax;
    end
    if (cmd.search_upd) begin
      lo  <= lo_next;
      hi  <= hi_next;
      thr <= mid_sum[mbe_pkg::WeightBits:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= mbe_pkg::NBits'(1);
      total     <= '0;
      eidx      <= '0;
      unions    <= '0;
      pvalid    <= '0;
      first     <= 1'b0;
      fail      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      if (cmd.load && total < mbe_pkg::EcntBits'(mbe_pkg::MaxEdges)) begin
        total <= total + mbe_pkg::EcntBits'(1);
      end
      if (cmd.search_init) begin
        first <= 1'b1;
        fail  <= 1'b0;
      end
      if (cmd.search_upd) begin
        first <= 1'b0;
        fail  <= fail_next;
      end
      if (cmd.chk_init) begin
        eidx   <= '0;
        unions <= '0;
        pvalid <= '0;
      end
      if (cmd.next_edge || cmd.start_a) eidx <= eidx + mbe_pkg::EcntBits'(1);
      if (cmd.link) begin
        pvalid[ra] <= 1'b1;
        unions     <= unions + mbe_pkg::NBits'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        total     <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result: empty set is feasible at zero; zero bottleneck or no tree is not
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (total == '0) begin
        max_tree_weight <= '0;
        feasible        <= 1'b1;
      end else if (fail || hi == '0) begin
        max_tree_weight <= '0;
        feasible        <= 1'b0;
      end else begin
        max_tree_weight <= hi;
        feasible        <= 1'b1;
      end
    end
  end

endmodule

// ----- design/mbe_ctrl.sv -----
// Controller state machine: sequences edge scans, root walks and the search.
// Uses mbe_pkg; talks to mbe_datapath by command and status only.
module mbe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           req_type,
  output logic           in_ready,
  input  mbe_pkg::stat_t stat,
  output mbe_pkg::cmd_t  cmd,
  output mbe_pkg::state_t state
);

  mbe_pkg::state_t state_next;

  assign in_ready = (state == mbe_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (req_type == mbe_pkg::ReqEdge) begin
            cmd.load = 1'b1;
          end else if (stat.total_zero) begin
            state_next = mbe_pkg::ST_EMIT;
          end else begin
            cmd.search_init = 1'b1;
            state_next      = mbe_pkg::ST_CHK_INIT;
          end
        end
      end
      mbe_pkg::ST_CHK_INIT: begin
        cmd.chk_init = 1'b1;
        state_next   = mbe_pkg::ST_E_RD;
      end
      mbe_pkg::ST_E_RD: begin
        cmd.e_rd   = 1'b1;
        state_next = mbe_pkg::ST_E_EVAL;
      end
      mbe_pkg::ST_E_EVAL: begin
        if (stat.edges_done) begin
          state_next = mbe_pkg::ST_CHK_END;
        end else if (stat.edge_skip) begin
          cmd.next_edge = 1'b1;
          state_next    = mbe_pkg::ST_E_RD;
        end else begin
          cmd.start_a = 1'b1;
          state_next  = mbe_pkg::ST_FA_RD;
        end
      end
      mbe_pkg::ST_FA_RD: begin
        cmd.f_rd   = 1'b1;
        state_next = mbe_pkg::ST_FA_EVAL;
      end
      mbe_pkg::ST_FA_EVAL: begin
        if (stat.is_root) begin
          cmd.save_ra = 1'b1;
          state_next  = mbe_pkg::ST_FB_RD;
        end else begin
          cmd.step   = 1'b1;
          state_next = mbe_pkg::ST_FA_RD;
        end
      end
      mbe_pkg::ST_FB_RD: begin
        cmd.f_rd   = 1'b1;
        state_next = mbe_pkg::ST_FB_EVAL;
      end
      mbe_pkg::ST_FB_EVAL: begin
        if (stat.is_root) begin
          // join the two trees unless already one
          cmd.link   = !stat.same_root;
          state_next = mbe_pkg::ST_E_RD;
        end else begin
          cmd.step   = 1'b1;
          state_next = mbe_pkg::ST_FB_RD;
        end
      end
      mbe_pkg::ST_CHK_END: begin
        cmd.search_upd = 1'b1;
        state_next     = stat.search_fin ? mbe_pkg::ST_EMIT : mbe_pkg::ST_CHK_INIT;
      end
      mbe_pkg::ST_EMIT: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = mbe_pkg::ST_IDLE;
        end
      end
      default: state_next = mbe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/mst_bottleneck_edge.sv -----
// Top level of the minimum bottleneck spanning tree block.
// Joins mbe_ctrl and mbe_datapath; uses mbe_pkg.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    req_type, end_a, end_b, edge_weight
//   out      source     out_valid / out_ready  max_tree_weight, feasible
//   cfg      sink       cfg_we                 cfg_wdata (vertex count)
//
// A finish runs up to 17 connectivity passes (one at the top weight, then
// sixteen bisection steps; a disconnected first pass ends the search). Each
// memory has a single read port. The result loads in the emit state, entered
// after the last pass or, for an empty set, straight from the finish transfer;
// it waits there until the output register is free.
// Reset is synchronous; no clearing pass is needed. A stalled result holds in
// the output register while new edges keep arriving.
module mst_bottleneck_edge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::NBits-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [mbe_pkg::VtxBits-1:0]    end_a,
  input  logic [mbe_pkg::VtxBits-1:0]    end_b,
  input  logic [mbe_pkg::WeightBits-1:0] edge_weight,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mbe_pkg::WeightBits-1:0] max_tree_weight,
  output logic                           feasible
);

  mbe_pkg::cmd_t   cmd;
  mbe_pkg::stat_t  stat;
  mbe_pkg::state_t state;

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  mbe_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .end_a           (end_a),
    .end_b           (end_b),
    .edge_weight     (edge_weight),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .max_tree_weight (max_tree_weight),
    .feasible        (feasible),
    .cmd             (cmd),
    .stat            (stat)
  );

  a_infeasible_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !feasible) |-> (max_tree_weight == '0))
    else $error("infeasible result with non-zero weight");

  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type) |=> !in_ready)
    else $error("input still open after finish transfer");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == mbe_pkg::ST_EMIT))
    else $error("result raised outside emit");

endmodule
